/* hw/rtl/lop_pkg.sv */
// Package for the lifetime offset planner: widths, command and status codes,
// controller state type and the command/status structs. No dependencies.
`default_nettype none
package lop_pkg;
    localparam int IdSlots    = 16;
    localparam int IdBits     = 4;
    localparam int OffBits    = 32;
    localparam int StepBits   = 16;
    localparam int SizeBits   = 24;
    localparam int AlignBits  = 13;
    localparam int CntBits    = 5;
    localparam int MaxRequests = 16;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_BADALIGN = 3'd2,
        ST_REVERSED = 3'd3,
        ST_DUP      = 3'd4,
        ST_FULL     = 3'd5,
        ST_OVERFLOW = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_PICKDONE,
        S_SCAN,
        S_SCANDONE,
        S_STEP,
        S_FINAL,
        S_EMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic add;        // validate and store the input word
        logic clear;      // invalidate all entries
        logic build_init; // clear placed flags, peak
        logic pick_init;  // start the next-request search
        logic pick_step;  // examine entry at counter
        logic scan_init;  // restart the counter and the best search
        logic scan_step;  // examine entry at counter for lowest offset
        logic gap_step;   // test the gap below the best entry
        logic final_place;// place the request at the candidate
        logic emit_init;  // start the emit walk
        logic emit_step;  // advance the emit walk
        logic load_out;   // load the output register
        logic ovf_out;    // load the overflow result
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_end;    // counter at last entry
        logic have_pick;  // a next request was found
        logic have_best;  // a best overlapping entry was found
        logic gap_fits;   // request fits below the best entry
        logic overflow;   // offset arithmetic overflowed
        logic emit_found; // a valid entry at emit counter, or the empty-table word
        logic emit_end;   // emit walk past the last entry
    } t_dp_sts;
endpackage
`default_nettype wire

/* hw/rtl/lifetime_offset_planner_unit.sv */
// Lifetime offset planner, top level: controller plus datapath. Uses lop_pkg.
// Add: result valid in the cycle after accept. Clear and unused code: no result.
// Build: a start step, then per request a pick walk over all ids, scan passes
// over all ids with a gap test after each that finds an overlap, and a place step;
// a last pick finds none. Emit: a word per used id, or one zero word; stalls hold it.
// Reset (synchronous, active low) empties the table and the output register.
`default_nettype none
module lifetime_offset_planner_unit
    import lop_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [IdBits-1:0]    i_req_id,
    input  wire logic [StepBits-1:0]  i_first_step,
    input  wire logic [StepBits-1:0]  i_last_step,
    input  wire logic [SizeBits-1:0]  i_byte_count,
    input  wire logic [AlignBits-1:0] i_alignment,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [2:0]                o_status,
    output logic [IdBits-1:0]         o_out_id,
    output logic [OffBits-1:0]        o_offset,
    output logic [SizeBits-1:0]       o_size_bytes,
    output logic [OffBits-1:0]        o_high_water,
    output logic                      o_last
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_take;

    assign w_take = o_valid && !i_stall;

    lop_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_cmd_code(i_cmd),
        .o_in_stall(o_stall), .i_out_busy(o_valid), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    lop_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_req_id(i_req_id), .i_first_step(i_first_step), .i_last_step(i_last_step),
        .i_byte_count(i_byte_count), .i_alignment(i_alignment),
        .i_out_take(w_take), .o_out_valid(o_valid),
        .o_status(o_status), .o_out_id(o_out_id), .o_offset(o_offset),
        .o_size_bytes(o_size_bytes), .o_high_water(o_high_water), .o_last(o_last)
    );
endmodule
`default_nettype wire

/* hw/rtl/lop_datapath.sv */
// Datapath of the lifetime offset planner: request table, sort search, gap
// scan, offset arithmetic and the output register. Uses lop_pkg.
`default_nettype none
module lop_datapath
    import lop_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic [IdBits-1:0]    i_req_id,
    input  wire logic [StepBits-1:0]  i_first_step,
    input  wire logic [StepBits-1:0]  i_last_step,
    input  wire logic [SizeBits-1:0]  i_byte_count,
    input  wire logic [AlignBits-1:0] i_alignment,
    input  wire logic                 i_out_take,
    output logic                      o_out_valid,
    output logic [2:0]                o_status,
    output logic [IdBits-1:0]         o_out_id,
    output logic [OffBits-1:0]        o_offset,
    output logic [SizeBits-1:0]       o_size_bytes,
    output logic [OffBits-1:0]        o_high_water,
    output logic                      o_last
);
    logic [StepBits-1:0]  r_first [IdSlots];
    logic [StepBits-1:0]  r_lst   [IdSlots];
    logic [SizeBits-1:0]  r_bytes [IdSlots];
    logic [AlignBits-1:0] r_align [IdSlots];
    logic [OffBits-1:0]   r_off   [IdSlots];
    logic [IdSlots-1:0]   r_valid, r_placed, r_used;

    logic [IdBits-1:0] r_cnt, r_pick, r_best;
    logic              r_have_pick, r_have_best;
    logic [OffBits:0]  r_cand;  // one spare bit catches overflow
    logic [OffBits:0]  r_peak;
    logic              r_emit_end;
    t_dp_sts           r_sts;

    // Add checks.
    logic [CntBits-1:0] w_count;
    t_status            w_add_st;
    always_comb begin
        w_count = '0;
        for (int i = 0; i < IdSlots; i++) w_count = w_count + CntBits'(r_valid[i]);
        if (i_byte_count == '0) w_add_st = ST_ZERO;
        else if (i_alignment == '0 || (i_alignment & (i_alignment - 1'b1)) != '0)
            w_add_st = ST_BADALIGN;
        else if (i_first_step > i_last_step) w_add_st = ST_REVERSED;
        else if (r_valid[i_req_id]) w_add_st = ST_DUP;
        else if (w_count >= CntBits'(MaxRequests)) w_add_st = ST_FULL;
        else w_add_st = ST_OK;
    end

    // Ordering compare of entry at counter against current pick.
    logic [IdBits-1:0] c, p;
    logic w_before;
    always_comb begin
        c = r_cnt;
        p = r_pick;
        if (r_first[c] != r_first[p]) w_before = r_first[c] < r_first[p];
        else if (r_align[c] != r_align[p]) w_before = r_align[c] > r_align[p];
        else if (r_bytes[c] != r_bytes[p]) w_before = r_bytes[c] > r_bytes[p];
        else if (r_lst[c] != r_lst[p]) w_before = r_lst[c] < r_lst[p];
        else w_before = c < p;
    end

    logic w_overlap;
    assign w_overlap = !(r_lst[c] < r_first[p] || r_lst[p] < r_first[c]);

    // Align the candidate up to the request alignment.
    logic [OffBits:0] w_mask, w_aligned, w_sz, w_boff, w_bend, w_fend;
    logic             w_al_ovf;
    always_comb begin
        w_mask    = (OffBits+1)'(r_align[p]) - 1'b1;
        w_aligned = (r_cand + w_mask) & ~w_mask;
        w_al_ovf  = w_aligned[OffBits];
        w_sz      = (OffBits+1)'(r_bytes[p]);
        w_boff    = {1'b0, r_off[r_best]};
        w_bend    = w_boff + (OffBits+1)'(r_bytes[r_best]);
        w_fend    = w_aligned + w_sz;
    end

    // Gap test and overflow outcome, registered and seen by the controller in the next cycle.
    logic w_gap_fits, w_ovf;
    always_comb begin
        w_gap_fits = !w_al_ovf && (w_aligned <= w_boff) && (w_sz <= w_boff - w_aligned);
        w_ovf = (i_cmd.gap_step && (w_al_ovf || (!w_gap_fits && w_bend[OffBits])))
             || (i_cmd.final_place && (w_al_ovf || w_fend[OffBits]));
    end

    // Entry at the counter is the highest valid id.
    logic w_is_last;
    always_comb begin
        w_is_last = 1'b1;
        for (int i = 0; i < IdSlots; i++)
            if (IdBits'(i) > c && r_valid[i]) w_is_last = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_placed    <= '0;
            r_sts       <= '0;
            o_out_valid <= 1'b0;
            r_emit_end  <= 1'b0;
        end else begin
            r_sts.overflow <= w_ovf;
            r_sts.gap_fits <= i_cmd.gap_step && w_gap_fits;
            if (i_out_take) o_out_valid <= 1'b0;
            if (i_cmd.add) begin
                if (w_add_st == ST_OK) begin
                    r_first[i_req_id] <= i_first_step;
                    r_lst[i_req_id]   <= i_last_step;
                    r_bytes[i_req_id] <= i_byte_count;
                    r_align[i_req_id] <= i_alignment;
                    r_valid[i_req_id] <= 1'b1;
                    r_placed[i_req_id] <= 1'b0;
                end
                o_out_valid  <= 1'b1;
                o_status     <= w_add_st;
                o_out_id     <= i_req_id;
                o_offset     <= '0;
                o_size_bytes <= i_byte_count;
                o_high_water <= '0;
                o_last       <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_valid  <= '0;
                r_placed <= '0;
            end
            if (i_cmd.build_init) begin
                r_placed <= '0;
                r_peak   <= '0;
                r_used   <= '0;
                r_cand   <= '0;
            end
            if (i_cmd.pick_init) begin
                r_cnt <= '0;
                r_have_pick <= 1'b0;
                r_sts.have_pick <= 1'b0;
                r_sts.cnt_end <= 1'b0;
            end
            if (i_cmd.pick_step) begin
                if (r_valid[c] && !r_placed[c] && (!r_have_pick || w_before)) begin
                    r_pick <= c;
                    r_have_pick <= 1'b1;
                    r_sts.have_pick <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
                r_sts.cnt_end <= (r_cnt == IdBits'(IdSlots - 2));
            end
            if (i_cmd.scan_init) begin
                r_cnt <= '0;
                r_have_best <= 1'b0;
                r_sts.have_best <= 1'b0;
                r_sts.cnt_end <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (r_placed[c] && !r_used[c] && w_overlap &&
                    (!r_have_best || r_off[c] < r_off[r_best])) begin
                    r_best <= c;
                    r_have_best <= 1'b1;
                    r_sts.have_best <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
                r_sts.cnt_end <= (r_cnt == IdBits'(IdSlots - 2));
            end
            if (i_cmd.gap_step) begin
                r_used[r_best] <= 1'b1;
                if (!w_gap_fits) r_cand <= (w_bend > w_aligned) ? w_bend : w_aligned;
            end
            if (i_cmd.final_place) begin
                if (!(w_al_ovf || w_fend[OffBits])) begin
                    r_off[p]    <= w_aligned[OffBits-1:0];
                    r_placed[p] <= 1'b1;
                    if (w_fend > r_peak) r_peak <= w_fend;
                end
                r_cand <= '0;
                r_used <= '0;
            end
            if (i_cmd.ovf_out) begin
                r_placed     <= '0;
                o_out_valid  <= 1'b1;
                o_status     <= ST_OVERFLOW;
                o_out_id     <= p;
                o_offset     <= '0;
                o_size_bytes <= '0;
                o_high_water <= '0;
                o_last       <= 1'b1;
            end
            if (i_cmd.emit_init) begin
                r_cnt <= '0;
                r_emit_end <= 1'b0;
            end
            if (i_cmd.emit_step) begin
                r_cnt <= r_cnt + 1'b1;
                // An empty table ends after its single all-zero word.
                r_emit_end <= (r_cnt == IdBits'(IdSlots - 1)) || (r_valid == '0);
            end
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
                o_status    <= ST_OK;
                if (r_valid == '0) begin
                    o_out_id     <= '0;
                    o_offset     <= '0;
                    o_size_bytes <= '0;
                    o_high_water <= '0;
                    o_last       <= 1'b1;
                end else begin
                    o_out_id     <= c;
                    o_offset     <= r_off[c];
                    o_size_bytes <= r_bytes[c];
                    o_last       <= w_is_last;
                    o_high_water <= w_is_last ? r_peak[OffBits-1:0] : '0;
                end
            end
        end
    end

    always_comb begin
        o_sts = r_sts;
        o_sts.emit_found = (r_valid[c] || (r_valid == '0)) && !r_emit_end;
        o_sts.emit_end   = r_emit_end;
    end
endmodule
`default_nettype wire

/* hw/rtl/lop_ctrl.sv */
// Controller state machine of the lifetime offset planner. Issues datapath
// commands and follows datapath status. Uses lop_pkg.
`default_nettype none
module lop_ctrl
    import lop_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_cmd_code,
    output logic            o_in_stall,
    input  wire logic       i_out_busy,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);
    t_state r_state, n_state;
    logic   w_acc;
    t_cmd   w_code;

    assign w_code = t_cmd'(i_cmd_code);
    assign o_in_stall = (r_state != S_IDLE) || i_out_busy;
    assign w_acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc && w_code == CMD_BUILD) n_state = S_PICK;
            S_PICK: if (i_sts.cnt_end) n_state = S_PICKDONE;
            S_PICKDONE: n_state = i_sts.have_pick ? S_SCAN : S_EMIT;
            S_SCAN: if (i_sts.cnt_end) n_state = S_SCANDONE;
            S_SCANDONE: n_state = i_sts.have_best ? S_STEP : S_FINAL;
            // The gap test outcome is visible here, in the cycle after the test.
            S_STEP: begin
                priority if (i_sts.overflow) n_state = S_IDLE;
                else if (i_sts.gap_fits) n_state = S_FINAL;
                else n_state = S_SCAN;
            end
            S_FINAL: n_state = i_sts.overflow ? S_IDLE : S_PICK;
            S_EMIT: begin
                priority if (i_sts.emit_end) n_state = S_IDLE;
                else if (i_sts.emit_found && !i_out_busy) n_state = S_OUT;
                else n_state = S_EMIT;
            end
            S_OUT: n_state = S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.add        = w_acc && (w_code == CMD_ADD);
                o_cmd.clear      = w_acc && (w_code == CMD_CLEAR);
                o_cmd.build_init = w_acc && (w_code == CMD_BUILD);
                o_cmd.pick_init  = w_acc && (w_code == CMD_BUILD);
            end
            S_PICK: o_cmd.pick_step = 1'b1;
            S_PICKDONE: begin
                o_cmd.scan_init = i_sts.have_pick;
                o_cmd.emit_init = !i_sts.have_pick;
            end
            S_SCAN: o_cmd.scan_step = 1'b1;
            S_SCANDONE: begin
                o_cmd.gap_step    = i_sts.have_best;
                o_cmd.final_place = !i_sts.have_best;
            end
            S_STEP: begin
                o_cmd.ovf_out     = i_sts.overflow;
                o_cmd.final_place = !i_sts.overflow && i_sts.gap_fits;
                o_cmd.scan_init   = !i_sts.overflow && !i_sts.gap_fits;
            end
            S_FINAL: begin
                o_cmd.ovf_out   = i_sts.overflow;
                o_cmd.pick_init = !i_sts.overflow;
            end
            // Unused ids are skipped without waiting for the output register.
            S_EMIT: begin
                o_cmd.load_out  = !i_sts.emit_end && i_sts.emit_found && !i_out_busy;
                o_cmd.emit_step = !i_sts.emit_end && !i_sts.emit_found;
            end
            S_OUT: o_cmd.emit_step = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for lifetime_offset_planner_unit: drives add, build and clear
// words, predicts each result word and compares it field by field. Depends on lop_pkg.
`default_nettype none
module tb
    import lop_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] OFF_MAX  = (64'd1 << OffBits) - 64'd1;
    localparam int          WD_LIMIT = 100000;

    typedef struct {
        bit                   pause;
        logic [1:0]           cmd;
        logic [IdBits-1:0]    id;
        logic [StepBits-1:0]  fs;
        logic [StepBits-1:0]  ls;
        logic [SizeBits-1:0]  bytes;
        logic [AlignBits-1:0] align;
    } t_plan_word;

    typedef struct {
        logic [2:0]          status;
        logic [IdBits-1:0]   id;
        logic [OffBits-1:0]  offset;
        logic [SizeBits-1:0] size;
        logic [OffBits-1:0]  peak;
        logic                last;
    } t_plan_result;

    logic                 i_clk, i_rst_n;
    logic                 i_valid = 1'b0;
    logic                 i_stall = 1'b0;
    logic                 o_stall, o_valid, o_last;
    logic [1:0]           i_cmd = CMD_NONE;
    logic [IdBits-1:0]    i_req_id = '0;
    logic [IdBits-1:0]    o_out_id;
    logic [StepBits-1:0]  i_first_step = '0;
    logic [StepBits-1:0]  i_last_step = '0;
    logic [SizeBits-1:0]  i_byte_count = '0;
    logic [SizeBits-1:0]  o_size_bytes;
    logic [AlignBits-1:0] i_alignment = '0;
    logic [2:0]           o_status;
    logic [OffBits-1:0]   o_offset, o_high_water;

    lifetime_offset_planner_unit dut (.*);

    // Predictor state, indexed by request id.
    logic [StepBits-1:0]  tab_first [IdSlots];
    logic [StepBits-1:0]  tab_last  [IdSlots];
    logic [SizeBits-1:0]  tab_bytes [IdSlots];
    logic [AlignBits-1:0] tab_align [IdSlots];
    logic [63:0]          tab_off   [IdSlots];
    bit                   tab_valid [IdSlots];
    bit                   tab_placed[IdSlots];

    t_plan_word   pending_words[$];
    t_plan_result expected_results[$];
    int errors = 0, n_adds = 0, n_builds = 0, n_results = 0, cyc = 0;
    int quiet_cycles = 0, idle_since_accept = 0;
    bit hold_done = 0;
    int hold_left = 0;

    function automatic bit placed_first(int a, int b);
        if (tab_first[a] != tab_first[b]) return tab_first[a] < tab_first[b];
        if (tab_align[a] != tab_align[b]) return tab_align[a] > tab_align[b];
        if (tab_bytes[a] != tab_bytes[b]) return tab_bytes[a] > tab_bytes[b];
        if (tab_last[a] != tab_last[b]) return tab_last[a] < tab_last[b];
        return a < b;
    endfunction

    function automatic bit lives_overlap(int a, int b);
        return !(tab_last[a] < tab_first[b] || tab_last[b] < tab_first[a]);
    endfunction

    // First fit below or between overlapping buffers; 0 on offset overflow.
    function automatic bit place_buffer(int r);
        logic [63:0] cand, m, sz, off, endv;
        bit used[IdSlots];
        int best;
        cand = 0;
        m = 64'(tab_align[r]) - 64'd1;
        sz = 64'(tab_bytes[r]);
        foreach (used[i]) used[i] = 0;
        forever begin
            best = -1;
            for (int i = 0; i < IdSlots; i++) begin
                if (!tab_placed[i] || used[i] || !lives_overlap(i, r)) continue;
                if (best < 0 || tab_off[i] < tab_off[best]) best = i;
            end
            if (best < 0) break;
            used[best] = 1;
            if (cand > OFF_MAX - m) return 0;
            cand = (cand + m) & ~m;
            off = tab_off[best];
            if (cand <= off && sz <= off - cand) break;
            if (off > OFF_MAX - 64'(tab_bytes[best])) return 0;
            endv = off + 64'(tab_bytes[best]);
            if (endv > cand) cand = endv;
        end
        if (cand > OFF_MAX - m) return 0;
        cand = (cand + m) & ~m;
        if (cand > OFF_MAX - sz) return 0;
        tab_off[r] = cand;
        tab_placed[r] = 1;
        return 1;
    endfunction

    task automatic predict_word(t_plan_word w);
        t_plan_result res;
        int count, nxt, lastid;
        logic [63:0] peak, endv;
        res = '{default: '0};
        res.last = 1;
        case (w.cmd)
            CMD_ADD: begin
                n_adds++;
                count = 0;
                foreach (tab_valid[i]) count += tab_valid[i];
                res.status = ST_OK;
                if (w.bytes == 0) res.status = ST_ZERO;
                else if (w.align == 0 || (w.align & (w.align - 1)) != 0) res.status = ST_BADALIGN;
                else if (w.fs > w.ls) res.status = ST_REVERSED;
                else if (tab_valid[w.id]) res.status = ST_DUP;
                else if (count >= MaxRequests) res.status = ST_FULL;
                if (res.status == ST_OK) begin
                    tab_first[w.id] = w.fs;
                    tab_last[w.id] = w.ls;
                    tab_bytes[w.id] = w.bytes;
                    tab_align[w.id] = w.align;
                    tab_valid[w.id] = 1;
                    tab_placed[w.id] = 0;
                end
                res.id = w.id;
                res.size = w.bytes;
                expected_results.insert(expected_results.size(), res);
            end
            CMD_CLEAR: begin
                foreach (tab_valid[i]) begin
                    tab_valid[i] = 0;
                    tab_placed[i] = 0;
                end
            end
            CMD_BUILD: begin
                n_builds++;
                foreach (tab_placed[i]) tab_placed[i] = 0;
                peak = 0;
                forever begin
                    nxt = -1;
                    for (int i = 0; i < IdSlots; i++) begin
                        if (!tab_valid[i] || tab_placed[i]) continue;
                        if (nxt < 0 || placed_first(i, nxt)) nxt = i;
                    end
                    if (nxt < 0) break;
                    if (!place_buffer(nxt)) begin
                        foreach (tab_placed[i]) tab_placed[i] = 0;
                        res.status = ST_OVERFLOW;
                        res.id = IdBits'(nxt);
                        expected_results.insert(expected_results.size(), res);
                        return;
                    end
                    endv = tab_off[nxt] + 64'(tab_bytes[nxt]);
                    if (endv > peak) peak = endv;
                end
                lastid = -1;
                foreach (tab_valid[i]) if (tab_valid[i]) lastid = i;
                if (lastid < 0) begin
                    expected_results.insert(expected_results.size(), res);
                    return;
                end
                for (int i = 0; i < IdSlots; i++) begin
                    if (!tab_valid[i]) continue;
                    res.status = ST_OK;
                    res.id = IdBits'(i);
                    res.offset = tab_off[i][OffBits-1:0];
                    res.size = tab_bytes[i];
                    res.last = (i == lastid);
                    res.peak = (i == lastid) ? peak[OffBits-1:0] : '0;
                    expected_results.insert(expected_results.size(), res);
                end
            end
            default: ;
        endcase
    endtask

    function automatic bit idle_now();
        if (cyc >= 3000 && cyc < 9000) return 0;
        return $urandom_range(99) < 27;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: loads the next word once the current one is accepted or none is offered.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) predict_word('{0, i_cmd, i_req_id, i_first_step, i_last_step,
                                        i_byte_count, i_alignment});
            if (pending_words.size() > 0 && pending_words[0].pause) begin
                i_valid <= 0;
                // A clear leaves no result, so hold new words until the result queue drains and stays quiet.
                if (quiet_cycles > 40) begin
                    void'(pending_words.pop_front());
                    quiet_cycles <= 0;
                end else if (expected_results.size() == 0 && !i_valid) begin
                    quiet_cycles <= quiet_cycles + 1;
                end else begin
                    quiet_cycles <= 0;
                end
            end else if (pending_words.size() > 0 && !idle_now()) begin
                i_cmd        <= pending_words[0].cmd;
                i_req_id     <= pending_words[0].id;
                i_first_step <= pending_words[0].fs;
                i_last_step  <= pending_words[0].ls;
                i_byte_count <= pending_words[0].bytes;
                i_alignment  <= pending_words[0].align;
                i_valid      <= 1;
                void'(pending_words.pop_front());
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Monitor: checks every accepted result word and drives the output stall.
    always @(posedge i_clk) begin
        t_plan_result e;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result word id=%0d status=%0d", o_out_id, o_status);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); errors++;
                    end
                    if (o_out_id !== e.id) begin
                        $error("out_id exp %0d got %0d", e.id, o_out_id); errors++;
                    end
                    if (o_offset !== e.offset) begin
                        $error("offset exp %0h got %0h", e.offset, o_offset); errors++;
                    end
                    if (o_size_bytes !== e.size) begin
                        $error("size_bytes exp %0h got %0h", e.size, o_size_bytes); errors++;
                    end
                    if (o_high_water !== e.peak) begin
                        $error("high_water exp %0h got %0h", e.peak, o_high_water); errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_last); errors++;
                    end
                end
            end
            // One long hold-off while the sender keeps going, to back up the block.
            if (!hold_done && n_results == 60) begin
                hold_done <= 1;
                hold_left <= 600;
                i_stall <= 1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= (hold_left > 1);
            end else begin
                i_stall <= idle_now();
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_since_accept <= 0;
        else idle_since_accept <= idle_since_accept + 1;
        if (idle_since_accept >= WD_LIMIT) begin
            $display("Stopped after %0d idle cycles with %0d result words checked.",
                     idle_since_accept, n_results);
            $display("** lifetime_offset_planner_unit: FAILED **");
            $finish;
        end
    end

    task automatic queue_word(logic [1:0] c, int id, int fs, int ls, int by, int al);
        pending_words.insert(pending_words.size(),
                             '{0, c, id[IdBits-1:0], fs[StepBits-1:0], ls[StepBits-1:0],
                               by[SizeBits-1:0], al[AlignBits-1:0]});
    endtask

    task automatic queue_pause();
        pending_words.insert(pending_words.size(), '{1, CMD_NONE, 0, 0, 0, 0, 0});
    endtask

    task automatic queue_random_words(int target);
        int n, fs, span, by;
        logic [1:0] c;
        while (pending_words.size() < target) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(1)) queue_word(CMD_CLEAR, 0, 0, 0, 0, 0);
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++) begin
                    fs = $urandom_range(9) == 0 ? $urandom_range(65535) : $urandom_range(40);
                    span = $urandom_range(20);
                    by = $urandom_range(19) == 0 ? $urandom_range(24'hFFFFFF, 1)
                                                 : $urandom_range(4096, 1);
                    if ($urandom_range(9) == 0)
                        queue_word(CMD_ADD, $urandom_range(15), $urandom_range(65535),
                                   $urandom_range(65535), $urandom_range(24'hFFFFFF),
                                   $urandom_range(8191));
                    else
                        queue_word(CMD_ADD, $urandom_range(15), fs,
                                   (fs + span > 65535) ? 65535 : fs + span,
                                   by, 1 << $urandom_range(12));
                end
                queue_word(CMD_BUILD, $urandom_range(15), 0, 0, 0, 0);
            end else begin
                c = 2'($urandom_range(3));
                if (c == CMD_BUILD) c = CMD_NONE;
                queue_word(c, $urandom_range(15), $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(24'hFFFFFF), $urandom_range(8191));
            end
        end
    endtask

    initial begin
        i_rst_n = 0;
        foreach (tab_valid[i]) begin
            tab_valid[i] = 0;
            tab_placed[i] = 0;
        end
        // Directed words: empty build, each rejection but full, extremes, overlaps, clear, unused code.
        queue_word(CMD_BUILD, 0, 0, 0, 0, 0);
        queue_word(CMD_ADD, 1, 0, 5, 0, 4);
        queue_word(CMD_ADD, 1, 0, 5, 64, 0);
        queue_word(CMD_ADD, 1, 0, 5, 64, 3);
        queue_word(CMD_ADD, 1, 0, 5, 64, 8191);
        queue_word(CMD_ADD, 1, 9, 5, 64, 8);
        queue_word(CMD_ADD, 1, 0, 5, 100, 8);
        queue_word(CMD_ADD, 1, 0, 5, 100, 8);
        queue_word(CMD_ADD, 15, 65535, 65535, 24'hFFFFFF, 4096);
        queue_word(CMD_ADD, 0, 0, 65535, 1, 1);
        queue_word(CMD_ADD, 2, 3, 7, 24'hFFFFFF, 4096);
        queue_word(CMD_ADD, 3, 6, 6, 200, 16);
        queue_word(CMD_ADD, 4, 0, 0, 50, 2);
        queue_word(CMD_BUILD, 0, 0, 0, 0, 0);
        queue_word(CMD_NONE, 7, 1, 1, 1, 1);
        queue_word(CMD_CLEAR, 0, 0, 0, 0, 0);
        queue_word(CMD_BUILD, 0, 0, 0, 0, 0);
        for (int k = 0; k < 16; k++) queue_word(CMD_ADD, k, k, k + 3, 256 + k, 1 << (k % 13));
        queue_word(CMD_ADD, 5, 0, 1, 8, 8);
        queue_word(CMD_BUILD, 0, 0, 0, 0, 0);
        queue_pause();
        queue_random_words(230);
        queue_pause();
        queue_random_words(460);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        wait (pending_words.size() == 0 && !i_valid && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d add words and %0d builds, %0d result words checked.",
                 n_adds, n_builds, n_results);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("** lifetime_offset_planner_unit: PASSED **");
        end else begin
            $display("** lifetime_offset_planner_unit: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
